@@ src/spq_pkg.sv @@
// shared types, codes and field widths for the sorted priority queue
package spq_pkg;

   localparam int CAPACITY_DEF   = 16;
   localparam int NAME_BYTES_DEF = 8;

   localparam int ACTION_W   = 3;
   localparam int PRIO_W     = 8;
   localparam int NAME_KEY_W = 64;
   localparam int POS_W      = 6;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH  = 3'd0,
      ACT_POP   = 3'd1,
      ACT_READ  = 3'd2,
      ACT_LIST  = 3'd3,
      ACT_CLEAR = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2
   } cell_op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic [ACTION_W-1:0]   action;
      logic [PRIO_W-1:0]     priority_req;
      logic [NAME_KEY_W-1:0] name_key;
      logic [POS_W-1:0]      position;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [PRIO_W-1:0]     out_priority;
      logic [NAME_KEY_W-1:0] out_name;
      logic [POS_W-1:0]      out_position;
      logic [OCC_W-1:0]      occupancy;
      logic                  last;
   } rsp_payload_type;

endpackage

@@ src/spq_cell.sv @@
// one queue slot: compares against the incoming entry and shifts with its neighbors
module spq_cell
   import spq_pkg::*;
#(
   parameter int NAME_W = 8 * NAME_BYTES_DEF
) (
   input  logic              clock,
   input  cell_op_type       op,
   input  logic              occupied,
   input  logic [PRIO_W-1:0] new_prio,
   input  logic [NAME_W-1:0] new_name,
   input  logic              left_ahead,
   input  logic [PRIO_W-1:0] left_prio,
   input  logic [NAME_W-1:0] left_name,
   input  logic [PRIO_W-1:0] right_prio,
   input  logic [NAME_W-1:0] right_name,
   output logic [PRIO_W-1:0] prio,
   output logic [NAME_W-1:0] name,
   output logic              ahead
);

   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [NAME_W-1:0] name_ff, name_in;

   // new entry goes in front of this slot
   assign ahead = !occupied || (new_prio > prio_ff) ||
                  ((new_prio == prio_ff) && (new_name <= name_ff));

   always_comb begin
      prio_in = prio_ff;
      name_in = name_ff;
      unique case (op)
         CELL_INSERT: begin
            priority if (left_ahead) begin
               prio_in = left_prio;
               name_in = left_name;
            end else if (ahead) begin
               prio_in = new_prio;
               name_in = new_name;
            end
         end
         CELL_SHIFT: begin
            prio_in = right_prio;
            name_in = right_name;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      name_ff <= name_in;
   end

   assign prio = prio_ff;
   assign name = name_ff;

endmodule

@@ src/spq_ctrl.sv @@
// action decode, entry count, scan sequencer and result register
module spq_ctrl
   import spq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int NAME_W   = 8 * NAME_BYTES_DEF,
   parameter int CNT_W    = $clog2(CAPACITY + 1),
   parameter int IDX_W    = $clog2(CAPACITY)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_payload_type   req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_payload_type   rsp_payload,
   input  logic [PRIO_W-1:0] head_prio,
   input  logic [NAME_W-1:0] head_name,
   input  logic [IDX_W-1:0]  ins_idx,
   output cell_op_type       cell_op,
   output logic [CNT_W-1:0]  count
);

   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   ctrl_state_type  state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0] target_ff, target_in;
   logic             is_list_ff, is_list_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   logic             out_free;
   logic             hit;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] step_ext;
   logic [POS_W:0]   ins_pos;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pos_ext  = CMP_W'(req_payload.position);
   assign cnt_ext  = CMP_W'(count_ff);
   assign step_ext = CMP_W'(step_ff);
   assign ins_pos  = (POS_W + 1)'(ins_idx) + (POS_W + 1)'(1);
   assign hit      = is_list_ff ? (step_ext < cnt_ext) : (step_ff == target_ff);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      target_in      = target_ff;
      is_list_in     = is_list_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      cell_op        = CELL_HOLD;
      req_stall      = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in              = '0;
               rsp_payload_in.status       = STAT_OK;
               rsp_payload_in.last         = 1'b1;
               rsp_payload_in.occupancy    = OCC_W'(count_ff);
               unique case (action_type'(req_payload.action))
                  ACT_PUSH: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_payload_in.status = STAT_FULL;
                     end else begin
                        cell_op                     = CELL_INSERT;
                        count_in                    = count_ff + CNT_W'(1);
                        rsp_payload_in.out_priority = req_payload.priority_req;
                        rsp_payload_in.out_name     =
                           NAME_KEY_W'(NAME_W'(req_payload.name_key));
                        rsp_payload_in.out_position = POS_W'(ins_pos);
                        rsp_payload_in.occupancy    = OCC_W'(count_ff + CNT_W'(1));
                     end
                  end
                  ACT_POP: begin
                     if (count_ff == '0) begin
                        rsp_payload_in.status = STAT_EMPTY;
                     end else begin
                        cell_op                     = CELL_SHIFT;
                        count_in                    = count_ff - CNT_W'(1);
                        rsp_payload_in.out_priority = head_prio;
                        rsp_payload_in.out_name     = NAME_KEY_W'(head_name);
                        rsp_payload_in.out_position = POS_W'(1);
                        rsp_payload_in.occupancy    = OCC_W'(count_ff - CNT_W'(1));
                     end
                  end
                  ACT_READ: begin
                     priority if (count_ff == '0) begin
                        rsp_payload_in.status = STAT_EMPTY;
                     end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                        rsp_payload_in.status = STAT_RANGE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                        step_in      = '0;
                        is_list_in   = 1'b0;
                        target_in    = IDX_W'(req_payload.position - POS_W'(1));
                     end
                  end
                  ACT_LIST: begin
                     if (count_ff == '0) begin
                        rsp_payload_in.status = STAT_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                        step_in      = '0;
                        is_list_in   = 1'b1;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in                 = '0;
                     rsp_payload_in.occupancy = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // the chain rotates a full turn; slot 0 shows entry number step
            if (!hit || out_free) begin
               cell_op = CELL_SHIFT;
               step_in = step_ff + IDX_W'(1);
               if (hit) begin
                  rsp_valid_in                = 1'b1;
                  rsp_payload_in.status       = STAT_OK;
                  rsp_payload_in.out_priority = head_prio;
                  rsp_payload_in.out_name     = NAME_KEY_W'(head_name);
                  rsp_payload_in.out_position = POS_W'(step_ext + CMP_W'(1));
                  rsp_payload_in.occupancy    = OCC_W'(count_ff);
                  rsp_payload_in.last         =
                     !is_list_ff || ((step_ext + CMP_W'(1)) == cnt_ext);
               end
               if (step_ff == IDX_W'(CAPACITY - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         is_list_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         is_list_ff   <= is_list_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff      <= target_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign count       = count_ff;

endmodule

@@ src/sorted_priority_queue.sv @@
// sorted priority queue top level: chain of slot cells and controller
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_payload_type
//   rsp     | out       | rsp_valid/rsp_stall | rsp_payload_type
//
// push, pop, clear and error cases are answered by a single result beat, with all slots
// comparing and shifting in parallel in the cell chain.
// read and list are accepted, then the chain makes one full turn, one list entry per
// cycle from the single head tap while the result is not stalled.
// reset empties the queue; slot contents are not cleared.
// a stalled result holds the scan in place; no new beat is taken until done.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int NAME_BYTES = NAME_BYTES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int NAME_W = 8 * NAME_BYTES;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = $clog2(CAPACITY);

   logic [PRIO_W-1:0] cell_prio [CAPACITY];
   logic [NAME_W-1:0] cell_name [CAPACITY];
   logic [CAPACITY-1:0] ahead;
   logic [NAME_W-1:0] new_name;
   logic [CNT_W-1:0]  count;
   logic [IDX_W-1:0]  ins_idx;
   cell_op_type       cell_op;

   assign new_name = NAME_W'(req_payload.name_key);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         spq_cell #(.NAME_W(NAME_W)) u_cell (
            .clock      (clock),
            .op         (cell_op),
            .occupied   (CNT_W'(i) < count),
            .new_prio   (req_payload.priority_req),
            .new_name   (new_name),
            .left_ahead (1'b0),
            .left_prio  (req_payload.priority_req),
            .left_name  (new_name),
            .right_prio (cell_prio[(i + 1) % CAPACITY]),
            .right_name (cell_name[(i + 1) % CAPACITY]),
            .prio       (cell_prio[i]),
            .name       (cell_name[i]),
            .ahead      (ahead[i])
         );
      end else begin : g_body
         spq_cell #(.NAME_W(NAME_W)) u_cell (
            .clock      (clock),
            .op         (cell_op),
            .occupied   (CNT_W'(i) < count),
            .new_prio   (req_payload.priority_req),
            .new_name   (new_name),
            .left_ahead (ahead[i-1]),
            .left_prio  (cell_prio[i-1]),
            .left_name  (cell_name[i-1]),
            .right_prio (cell_prio[(i + 1) % CAPACITY]),
            .right_name (cell_name[(i + 1) % CAPACITY]),
            .prio       (cell_prio[i]),
            .name       (cell_name[i]),
            .ahead      (ahead[i])
         );
      end
   end

   // index of the first slot the new entry goes ahead of
   always_comb begin
      ins_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (ahead[i] && (i == 0 || !ahead[(i == 0) ? 0 : i - 1])) begin
            ins_idx = ins_idx | IDX_W'(i);
         end
      end
   end

   spq_ctrl #(
      .CAPACITY (CAPACITY),
      .NAME_W   (NAME_W),
      .CNT_W    (CNT_W),
      .IDX_W    (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .head_prio   (cell_prio[0]),
      .head_name   (cell_name[0]),
      .ins_idx     (ins_idx),
      .cell_op     (cell_op),
      .count       (count)
   );

endmodule

@@ tb/sorted_priority_queue_checker.sv @@
// checker for the sorted priority queue: predicts every action and compares result beats in order
module sorted_priority_queue_checker
   import spq_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int NAME_BYTES = NAME_BYTES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_payload,
   output int              fail_count,
   output int              pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [NAME_KEY_W-1:0] NAME_MASK =
      {NAME_KEY_W{1'b1}} >> (NAME_KEY_W - 8 * NAME_BYTES);
   localparam int REPORT_LIMIT = 10;

   logic [PRIO_W-1:0]     held_prio [CAPACITY];
   logic [NAME_KEY_W-1:0] held_name [CAPACITY];
   int                    held = 0;
   rsp_payload_type       due_results [$];
   int                    errors = 0;

   function automatic void apply_action(input req_payload_type beat);
      rsp_payload_type       r;
      logic [NAME_KEY_W-1:0] key;
      int                    at;
      r = '0;
      r.last = 1'b1;
      key = beat.name_key & NAME_MASK;
      case (beat.action)
         ACT_PUSH: begin
            if (held >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               at = 0;
               while (at < held && (held_prio[at] > beat.priority_req ||
                      (held_prio[at] == beat.priority_req && key > held_name[at])))
                  at++;
               for (int i = held; i > at; i--) begin
                  held_prio[i] = held_prio[i-1];
                  held_name[i] = held_name[i-1];
               end
               held_prio[at] = beat.priority_req;
               held_name[at] = key;
               held++;
               r.out_priority = beat.priority_req;
               r.out_name     = key;
               r.out_position = POS_W'(at + 1);
            end
         end
         ACT_POP: begin
            if (held == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.out_priority = held_prio[0];
               r.out_name     = held_name[0];
               r.out_position = POS_W'(1);
               for (int i = 1; i < held; i++) begin
                  held_prio[i-1] = held_prio[i];
                  held_name[i-1] = held_name[i];
               end
               held--;
            end
         end
         ACT_READ: begin
            if (held == 0) begin
               r.status = STAT_EMPTY;
            end else if (beat.position == 0 || beat.position > held) begin
               r.status = STAT_RANGE;
            end else begin
               r.out_priority = held_prio[beat.position - 1];
               r.out_name     = held_name[beat.position - 1];
               r.out_position = beat.position;
            end
         end
         ACT_LIST: begin
            if (held == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               for (int i = 0; i < held; i++) begin
                  r.status       = STAT_OK;
                  r.out_priority = held_prio[i];
                  r.out_name     = held_name[i];
                  r.out_position = POS_W'(i + 1);
                  r.occupancy    = OCC_W'(held);
                  r.last         = (i == held - 1);
                  due_results.push_back(r);
               end
               return;
            end
         end
         ACT_CLEAR: begin
            held = 0;
         end
         default: begin
         end
      endcase
      r.occupancy = OCC_W'(held);
      due_results.push_back(r);
   endfunction

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (reset) begin
         held = 0;
         due_results.delete();
      end else begin
         if (req_valid && !req_stall)
            apply_action(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               if (errors < REPORT_LIMIT)
                  $display("unexpected result beat %h", rsp_payload);
               errors++;
            end else begin
               want = due_results.pop_front();
               if (rsp_payload.status !== want.status ||
                   rsp_payload.out_priority !== want.out_priority ||
                   rsp_payload.out_name !== want.out_name ||
                   rsp_payload.out_position !== want.out_position ||
                   rsp_payload.occupancy !== want.occupancy ||
                   rsp_payload.last !== want.last) begin
                  if (errors < REPORT_LIMIT) begin
                     $display("result mismatch want st=%0d pr=%0d nm=%h pos=%0d occ=%0d last=%0b",
                        want.status, want.out_priority, want.out_name,
                        want.out_position, want.occupancy, want.last);
                     $display("                got  st=%0d pr=%0d nm=%h pos=%0d occ=%0d last=%0b",
                        rsp_payload.status, rsp_payload.out_priority, rsp_payload.out_name,
                        rsp_payload.out_position, rsp_payload.occupancy, rsp_payload.last);
                  end
                  errors++;
               end
            end
         end
      end
      fail_count <= errors;
      pending    <= due_results.size();
   end

endmodule

@@ tb/sorted_priority_queue_tb.sv @@
// testbench top for the sorted priority queue: stimulus, handshake idling and verdict
module sorted_priority_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spq_pkg::*;

   localparam int                  RANDOM_ITEMS  = 200;
   localparam int                  QUIET_LIMIT   = 4000;
   localparam int                  SETTLE_CYCLES = 2 * CAPACITY_DEF + 8;
   localparam int                  MAX_GAP       = 4;
   localparam logic [ACTION_W-1:0] ACT_SPARE_LO  = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HI  = 3'd7;
   localparam logic [NAME_KEY_W-1:0] NAME_ALICE  = 64'h414C_4943_4500_0000;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   int              fail_count;
   int              pending;
   logic            calm_req = 1'b0;
   logic            calm_rsp = 1'b0;
   int              real_beats = 0;

   always #1 clock = ~clock;

   sorted_priority_queue dut (.*);

   sorted_priority_queue_checker scoreboard (.*);

   function automatic req_payload_type beat_of(input logic [ACTION_W-1:0] act,
         input logic [PRIO_W-1:0] pr, input logic [NAME_KEY_W-1:0] nm,
         input logic [POS_W-1:0] pos);
      req_payload_type b;
      b.action       = act;
      b.priority_req = pr;
      b.name_key     = nm;
      b.position     = pos;
      return b;
   endfunction

   function automatic req_payload_type random_beat();
      int                    pick;
      logic [ACTION_W-1:0]   act;
      logic [PRIO_W-1:0]     pr;
      logic [NAME_KEY_W-1:0] nm;
      logic [POS_W-1:0]      pos;
      pick = $urandom_range(0, 99);
      if (pick < 40) act = ACT_PUSH;
      else if (pick < 58) act = ACT_POP;
      else if (pick < 78) act = ACT_READ;
      else if (pick < 88) act = ACT_LIST;
      else if (pick < 92) act = ACT_CLEAR;
      else act = ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      case ($urandom_range(0, 3))
         0: pr = PRIO_W'($urandom_range(60, 63));
         1: pr = $urandom_range(0, 1) ? '1 : '0;
         default: pr = PRIO_W'($urandom);
      endcase
      // short names from a tiny alphabet make equal keys common
      nm = $urandom_range(0, 1) ? {$urandom, $urandom}
                                : {8'($urandom_range(8'h41, 8'h43)), 56'h0};
      pos = $urandom_range(0, 2) == 0 ? POS_W'($urandom_range(0, 63))
                                      : POS_W'($urandom_range(1, CAPACITY_DEF));
      return beat_of(act, pr, nm, pos);
   endfunction

   task automatic send_beat(input req_payload_type beat);
      int gap;
      gap = calm_req ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (!(req_valid && !req_stall));
      if (beat.action < ACT_SPARE_LO)
         real_beats++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
   endtask

   initial begin : rsp_sink
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = calm_rsp ? 0 : $urandom_range(0, MAX_GAP);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      req_payload_type b;
      int              chunk;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // empty queue cases
      send_beat(beat_of(ACT_POP, '1, '1, '1));
      send_beat(beat_of(ACT_READ, '0, '0, 6'd1));
      send_beat(beat_of(ACT_READ, '0, '0, 6'd0));
      send_beat(beat_of(ACT_LIST, '0, '0, '0));
      // key extremes, name ties and duplicate keys
      send_beat(beat_of(ACT_PUSH, 8'd0, 64'h0, '0));
      send_beat(beat_of(ACT_PUSH, 8'd255, '1, '0));
      send_beat(beat_of(ACT_PUSH, 8'd255, 64'h0, '0));
      send_beat(beat_of(ACT_PUSH, 8'd255, '1, '1));
      send_beat(beat_of(ACT_PUSH, 8'd128, NAME_ALICE, '0));
      // read positions around the bounds
      send_beat(beat_of(ACT_READ, '0, '0, 6'd0));
      send_beat(beat_of(ACT_READ, '0, '0, 6'd5));
      send_beat(beat_of(ACT_READ, '0, '0, 6'd6));
      send_beat(beat_of(ACT_READ, '1, '1, 6'd63));
      send_beat(beat_of(ACT_READ, '0, '0, 6'd1));
      send_beat(beat_of(ACT_LIST, '0, '0, '0));
      for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
         send_beat(beat_of(ACTION_W'(a), '1, '1, '1));
      send_beat(beat_of(ACT_POP, '0, '0, '0));
      send_beat(beat_of(ACT_CLEAR, '1, '1, '1));
      send_beat(beat_of(ACT_POP, '0, '0, '0));
      hold_until_drained();

      real_beats = 0;
      chunk = 0;
      while (real_beats < RANDOM_ITEMS) begin
         calm_req = ($urandom_range(0, 3) == 0);
         calm_rsp = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0) begin
            // fill past capacity, then walk and drain the head
            b = random_beat();
            b.action = ACT_CLEAR;
            send_beat(b);
            repeat (CAPACITY_DEF + 2) begin
               b = random_beat();
               b.action = ACT_PUSH;
               send_beat(b);
            end
            b = random_beat();
            b.action = ACT_LIST;
            send_beat(b);
            repeat ($urandom_range(1, 4)) begin
               b = random_beat();
               b.action = ACT_POP;
               send_beat(b);
            end
         end else begin
            repeat (20) send_beat(random_beat());
         end
         if (chunk == 2)
            hold_until_drained();
         chunk++;
      end

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
